FILE: rtl/c2p_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c2p_pkg
// Shared constants and types of the cartesian to polar converter: binary
// angle constants, the arctangent steps of the CORDIC and the root widths.
// ----------------------------------------------------------------------------
package c2p_pkg;

   // result field widths
   localparam int MAG_W   = 16;
   localparam int PHASE_W = 17;

   // CORDIC: inputs are scaled up before the rotations, angles are binary
   // angles with a full turn of 2^32
   localparam int GUARD_SHIFT = 24;
   localparam int MAX_ITERS   = 32;
   localparam int ANGLE_W     = 32;
   localparam int Z_W         = 34;

   localparam logic [ANGLE_W-1:0] QUARTER_TURN = 32'h4000_0000;
   localparam logic [ANGLE_W-1:0] HALF_TURN    = 32'h8000_0000;

   localparam logic [ANGLE_W-1:0] ATAN_TURNS [MAX_ITERS] = '{
      32'h2000_0000, 32'h12E4_051E, 32'h09FB_385B, 32'h0511_11D4,
      32'h028B_0D43, 32'h0145_D7E1, 32'h00A2_F61E, 32'h0051_7C55,
      32'h0028_BE53, 32'h0014_5F2F, 32'h000A_2F98, 32'h0005_17CC,
      32'h0002_8BE6, 32'h0001_45F3, 32'h0000_A2FA, 32'h0000_517D,
      32'h0000_28BE, 32'h0000_145F, 32'h0000_0A30, 32'h0000_0518,
      32'h0000_028C, 32'h0000_0146, 32'h0000_00A3, 32'h0000_0051,
      32'h0000_0029, 32'h0000_0014, 32'h0000_000A, 32'h0000_0005,
      32'h0000_0003, 32'h0000_0001, 32'h0000_0001, 32'h0000_0000
   };

   // binary angle to 2^-13 rad: times round(pi * 2^30), then down by 2^48
   localparam int                 PROD_W      = 64;
   localparam int                 PHASE_SHIFT = 48;
   localparam logic [ANGLE_W-1:0] PI_Q30      = 32'd3373259426;
   localparam logic [PROD_W:0]    ROUND_HALF  = 65'h0_0000_8000_0000_0000;

   // square root: 32-bit radicand, one result bit per step
   localparam int SQRT_W     = 32;
   localparam int SQRT_ITERS = 16;
   localparam int ROOT_W     = 16;
   localparam int SAT_W      = 33;

   // above this sum of squares the rounded root exceeds 16 bits
   localparam logic [SAT_W-1:0]  SAT_LIMIT = 33'd4294901760;
   localparam logic [MAG_W-1:0]  MAG_MAX   = 16'hFFFF;

   typedef struct packed {
      logic re_zero;
      logic im_zero;
      logic re_neg;
      logic im_neg;
      logic mag_sat;
   } c2p_flags_type;

endpackage

FILE: rtl/c2p_cordic.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c2p_cordic
// Unrolled vectoring CORDIC, one rotation per register stage; stages past
// NITER only delay. Returns the accumulated binary angle of (ax, ay), unclamped.
// ----------------------------------------------------------------------------
module c2p_cordic #(
   parameter int DATA_WIDTH = 16,
   parameter int NSTAGES    = 16,
   parameter int NITER      = 16
) (
   input  logic                           clock,
   input  logic                           ce,
   input  logic [DATA_WIDTH-1:0]          ax,
   input  logic [DATA_WIDTH-1:0]          ay,
   output logic signed [c2p_pkg::Z_W-1:0] z
);

   localparam int CW = DATA_WIDTH + c2p_pkg::GUARD_SHIFT + 3;
   localparam int ZW = c2p_pkg::Z_W;

   logic signed [CW-1:0] x0;
   logic signed [CW-1:0] y0;

   logic signed [CW-1:0] x_ff [NSTAGES];
   logic signed [CW-1:0] y_ff [NSTAGES];
   logic signed [ZW-1:0] z_ff [NSTAGES];
   logic signed [CW-1:0] x_in [NSTAGES];
   logic signed [CW-1:0] y_in [NSTAGES];
   logic signed [ZW-1:0] z_in [NSTAGES];

   assign x0 = CW'(ax) << c2p_pkg::GUARD_SHIFT;
   assign y0 = CW'(ay) << c2p_pkg::GUARD_SHIFT;

   for (genvar i = 0; i < NSTAGES; i++) begin : g_stage
      logic signed [CW-1:0] x_p;
      logic signed [CW-1:0] y_p;
      logic signed [ZW-1:0] z_p;

      if (i == 0) begin : g_first
         assign x_p = x0;
         assign y_p = y0;
         assign z_p = '0;
      end else begin : g_next
         assign x_p = x_ff[i-1];
         assign y_p = y_ff[i-1];
         assign z_p = z_ff[i-1];
      end

      if (i < NITER) begin : g_rot
         localparam logic [CW-1:0] LOW_MASK = (CW'(1) << i) - CW'(1);
         localparam logic signed [ZW-1:0] ANG = ZW'(c2p_pkg::ATAN_TURNS[i]);

         logic                 y_pos;
         logic                 y_neg;
         logic                 y_cy;
         logic signed [CW-1:0] y_rt;
         logic signed [CW-1:0] x_rt;

         assign y_neg = y_p[CW-1];
         assign y_pos = !y_p[CW-1] && (y_p != '0);
         // negative values shift as their magnitude: round toward zero
         assign y_cy  = y_neg && ((y_p & LOW_MASK) != '0);
         assign y_rt  = y_p >>> i;
         assign x_rt  = x_p >>> i;

         assign x_in[i] = y_pos ? (x_p + y_rt) :
                          (y_neg ? (x_p - y_rt - $signed(CW'(y_cy))) : x_p);
         assign y_in[i] = y_pos ? (y_p - x_rt) : (y_neg ? (y_p + x_rt) : y_p);
         assign z_in[i] = y_pos ? (z_p + ANG) : (y_neg ? (z_p - ANG) : z_p);
      end else begin : g_pass
         assign x_in[i] = x_p;
         assign y_in[i] = y_p;
         assign z_in[i] = z_p;
      end

      always_ff @(posedge clock) begin
         if (ce) begin
            x_ff[i] <= x_in[i];
            y_ff[i] <= y_in[i];
            z_ff[i] <= z_in[i];
         end
      end
   end

   assign z = z_ff[NSTAGES-1];

endmodule

FILE: rtl/c2p_isqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c2p_isqrt
// Pipelined integer square root, one result bit per register stage, with
// the remainder kept for rounding. Stages past the last bit only delay.
// ----------------------------------------------------------------------------
module c2p_isqrt #(
   parameter int LATENCY = 16
) (
   input  logic                              clock,
   input  logic                              ce,
   input  logic [c2p_pkg::SQRT_W-1:0]        radicand,
   output logic [c2p_pkg::ROOT_W-1:0]        root,
   output logic [c2p_pkg::SQRT_W-1:0]        remainder
);

   localparam int SW = c2p_pkg::SQRT_W;

   logic [SW-1:0] s_ff [LATENCY];
   logic [SW-1:0] r_ff [LATENCY];
   logic [SW-1:0] s_in [LATENCY];
   logic [SW-1:0] r_in [LATENCY];

   for (genvar k = 0; k < LATENCY; k++) begin : g_stage
      logic [SW-1:0] s_p;
      logic [SW-1:0] r_p;

      if (k == 0) begin : g_first
         assign s_p = radicand;
         assign r_p = '0;
      end else begin : g_next
         assign s_p = s_ff[k-1];
         assign r_p = r_ff[k-1];
      end

      if (k < c2p_pkg::SQRT_ITERS) begin : g_bit
         localparam logic [SW-1:0] BIT = SW'(1) << (SW - 2 - 2 * k);

         logic [SW:0] trial;
         logic        take;

         assign trial   = {1'b0, r_p} + {1'b0, BIT};
         assign take    = {1'b0, s_p} >= trial;
         assign s_in[k] = take ? (s_p - trial[SW-1:0]) : s_p;
         assign r_in[k] = take ? ((r_p >> 1) + BIT) : (r_p >> 1);
      end else begin : g_pass
         assign s_in[k] = s_p;
         assign r_in[k] = r_p;
      end

      always_ff @(posedge clock) begin
         if (ce) begin
            s_ff[k] <= s_in[k];
            r_ff[k] <= r_in[k];
         end
      end
   end

   assign root      = r_ff[LATENCY-1][c2p_pkg::ROOT_W-1:0];
   assign remainder = s_ff[LATENCY-1];

endmodule

FILE: rtl/cartesian_to_polar_converter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cartesian_to_polar_converter
// Complex sample in, rounded magnitude and quadrant-corrected phase out.
//
//   channel   direction  ports                                   handshake
//   request   in         req_real_part, req_imag_part            req_valid/req_stall
//   response  out        rsp_magnitude, rsp_phase, rsp_zero_input rsp_valid/rsp_stall
//
// One request per clock while the response is not stalled. The pipeline runs
// the unrolled CORDIC (one rotation a stage) beside the root pipeline
// (one bit a stage), plus abs, square, sum, angle select, scale, round.
// Synchronous reset clears only the valid bits of the pipeline.
// A stalled response freezes the whole pipeline; req_stall is high only while
// the output register holds a response that is being stalled.
// ----------------------------------------------------------------------------
module cartesian_to_polar_converter #(
   parameter int DATA_WIDTH    = 16,
   parameter int CORDIC_STAGES = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [DATA_WIDTH-1:0]        req_real_part,
   input  logic signed [DATA_WIDTH-1:0]        req_imag_part,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [c2p_pkg::MAG_W-1:0]           rsp_magnitude,
   output logic signed [c2p_pkg::PHASE_W-1:0]  rsp_phase,
   output logic                                rsp_zero_input
);

   localparam int NCORD = (CORDIC_STAGES > c2p_pkg::MAX_ITERS) ?
                          c2p_pkg::MAX_ITERS : CORDIC_STAGES;
   localparam int NCORE = (NCORD > c2p_pkg::SQRT_ITERS) ? NCORD : c2p_pkg::SQRT_ITERS;
   localparam int PW    = 2 * DATA_WIDTH;
   localparam int SUMW  = PW + 1;
   localparam int EXTW  = (SUMW > c2p_pkg::SAT_W) ? SUMW : c2p_pkg::SAT_W;
   localparam int AW    = c2p_pkg::ANGLE_W;
   localparam int ZW    = c2p_pkg::Z_W;
   localparam int PHW   = c2p_pkg::PHASE_W;

   localparam logic signed [PHW-1:0] PHASE_MIN = -17'sd12868;
   localparam logic signed [PHW-1:0] PHASE_MAX = 17'sd38604;

   logic ce;

   // stage a: sign, zero tests, absolute values
   logic                   a_vld_ff;
   c2p_pkg::c2p_flags_type a_flags_ff;
   c2p_pkg::c2p_flags_type a_flags_in;
   logic [DATA_WIDTH-1:0]  a_are_ff;
   logic [DATA_WIDTH-1:0]  a_aim_ff;
   logic [DATA_WIDTH-1:0]  a_are_in;
   logic [DATA_WIDTH-1:0]  a_aim_in;

   // stage b: squares
   logic                   b_vld_ff;
   c2p_pkg::c2p_flags_type b_flags_ff;
   logic [DATA_WIDTH-1:0]  b_are_ff;
   logic [DATA_WIDTH-1:0]  b_aim_ff;
   logic [PW-1:0]          b_sqre_ff;
   logic [PW-1:0]          b_sqim_ff;
   logic [PW-1:0]          b_sqre_in;
   logic [PW-1:0]          b_sqim_in;

   // stage c: sum of squares and saturation test
   logic                         c_vld_ff;
   c2p_pkg::c2p_flags_type       c_flags_ff;
   c2p_pkg::c2p_flags_type       c_flags_in;
   logic [DATA_WIDTH-1:0]        c_are_ff;
   logic [DATA_WIDTH-1:0]        c_aim_ff;
   logic [c2p_pkg::SQRT_W-1:0]   c_sum_ff;
   logic [EXTW-1:0]              c_sum_ext;

   // core: CORDIC and root side by side
   logic                         core_vld_ff   [NCORE];
   c2p_pkg::c2p_flags_type       core_flags_ff [NCORE];
   logic signed [ZW-1:0]         core_z;
   logic [c2p_pkg::ROOT_W-1:0]   core_root;
   logic [c2p_pkg::SQRT_W-1:0]   core_rem;

   // stage d: angle select, magnitude rounding
   c2p_pkg::c2p_flags_type       d_flags;
   logic [AW-1:0]                d_theta;
   logic [AW-1:0]                d_theta_sel;
   logic [c2p_pkg::ROOT_W:0]     d_round;
   logic                         d_vld_ff;
   logic                         d_zero_ff;
   logic                         d_neg_ff;
   logic                         d_neg_in;
   logic [AW-1:0]                d_mang_ff;
   logic [AW-1:0]                d_mang_in;
   logic [c2p_pkg::MAG_W-1:0]    d_mag_ff;
   logic [c2p_pkg::MAG_W-1:0]    d_mag_in;

   // stage e: scale to radians
   logic                         e_vld_ff;
   logic                         e_zero_ff;
   logic                         e_neg_ff;
   logic [c2p_pkg::MAG_W-1:0]    e_mag_ff;
   logic [c2p_pkg::PROD_W-1:0]   e_prod_ff;
   logic [c2p_pkg::PROD_W-1:0]   e_prod_in;

   // output register
   logic                         rsp_valid_ff;
   logic [c2p_pkg::MAG_W-1:0]    rsp_magnitude_ff;
   logic signed [PHW-1:0]        rsp_phase_ff;
   logic signed [PHW-1:0]        rsp_phase_in;
   logic                         rsp_zero_input_ff;
   logic [c2p_pkg::PROD_W:0]     f_rounded;
   logic [PHW-1:0]               f_phmag;

   assign ce        = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !ce;

   // ---- stage a
   always_comb begin
      a_flags_in.re_zero = (req_real_part == '0);
      a_flags_in.im_zero = (req_imag_part == '0);
      a_flags_in.re_neg  = req_real_part[DATA_WIDTH-1];
      a_flags_in.im_neg  = req_imag_part[DATA_WIDTH-1];
      a_flags_in.mag_sat = 1'b0;
      // most negative input wraps to its own pattern, which reads right unsigned
      a_are_in = req_real_part[DATA_WIDTH-1] ? DATA_WIDTH'(-req_real_part) : req_real_part;
      a_aim_in = req_imag_part[DATA_WIDTH-1] ? DATA_WIDTH'(-req_imag_part) : req_imag_part;
   end

   // ---- stage b
   assign b_sqre_in = PW'(a_are_ff) * PW'(a_are_ff);
   assign b_sqim_in = PW'(a_aim_ff) * PW'(a_aim_ff);

   // ---- stage c
   always_comb begin
      c_sum_ext          = EXTW'(b_sqre_ff) + EXTW'(b_sqim_ff);
      c_flags_in         = b_flags_ff;
      c_flags_in.mag_sat = c_sum_ext > EXTW'(c2p_pkg::SAT_LIMIT);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
         b_vld_ff <= 1'b0;
         c_vld_ff <= 1'b0;
      end else if (ce) begin
         a_vld_ff <= req_valid;
         b_vld_ff <= a_vld_ff;
         c_vld_ff <= b_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         a_flags_ff <= a_flags_in;
         a_are_ff   <= a_are_in;
         a_aim_ff   <= a_aim_in;
         b_flags_ff <= a_flags_ff;
         b_are_ff   <= a_are_ff;
         b_aim_ff   <= a_aim_ff;
         b_sqre_ff  <= b_sqre_in;
         b_sqim_ff  <= b_sqim_in;
         c_flags_ff <= c_flags_in;
         c_are_ff   <= b_are_ff;
         c_aim_ff   <= b_aim_ff;
         c_sum_ff   <= c_sum_ext[c2p_pkg::SQRT_W-1:0];
      end
   end

   // ---- core
   c2p_cordic #(
      .DATA_WIDTH (DATA_WIDTH),
      .NSTAGES    (NCORE),
      .NITER      (NCORD)
   ) u_cordic (
      .clock (clock),
      .ce    (ce),
      .ax    (c_are_ff),
      .ay    (c_aim_ff),
      .z     (core_z)
   );

   c2p_isqrt #(
      .LATENCY (NCORE)
   ) u_isqrt (
      .clock     (clock),
      .ce        (ce),
      .radicand  (c_sum_ff),
      .root      (core_root),
      .remainder (core_rem)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NCORE; k++) begin
            core_vld_ff[k] <= 1'b0;
         end
      end else if (ce) begin
         core_vld_ff[0] <= c_vld_ff;
         for (int k = 1; k < NCORE; k++) begin
            core_vld_ff[k] <= core_vld_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         core_flags_ff[0] <= c_flags_ff;
         for (int k = 1; k < NCORE; k++) begin
            core_flags_ff[k] <= core_flags_ff[k-1];
         end
      end
   end

   // ---- stage d
   always_comb begin
      d_flags = core_flags_ff[NCORE-1];

      // first-quadrant angle limited to 0 .. quarter turn
      priority if (core_z[ZW-1]) begin
         d_theta = '0;
      end else if (core_z > $signed(ZW'(c2p_pkg::QUARTER_TURN))) begin
         d_theta = c2p_pkg::QUARTER_TURN;
      end else begin
         d_theta = core_z[AW-1:0];
      end
      d_theta_sel = d_flags.im_zero ? '0 : d_theta;

      priority if (d_flags.re_zero && d_flags.im_zero) begin
         d_mang_in = '0;
         d_neg_in  = 1'b0;
      end else if (d_flags.re_zero) begin
         d_mang_in = c2p_pkg::QUARTER_TURN;
         d_neg_in  = d_flags.im_neg;
      end else if (d_flags.re_neg) begin
         d_mang_in = d_flags.im_neg ? (c2p_pkg::HALF_TURN + d_theta_sel)
                                    : (c2p_pkg::HALF_TURN - d_theta_sel);
         d_neg_in  = 1'b0;
      end else begin
         d_mang_in = d_theta_sel;
         d_neg_in  = d_flags.im_neg;
      end

      // round to nearest: step up when the remainder passes the root
      d_round  = {1'b0, core_root} +
                 (c2p_pkg::ROOT_W + 1)'(core_rem > c2p_pkg::SQRT_W'(core_root));
      d_mag_in = (d_flags.mag_sat || d_round[c2p_pkg::ROOT_W]) ?
                 c2p_pkg::MAG_MAX : d_round[c2p_pkg::MAG_W-1:0];
   end

   // ---- stage e
   assign e_prod_in = c2p_pkg::PROD_W'(d_mang_ff) * c2p_pkg::PROD_W'(c2p_pkg::PI_Q30);

   // ---- output stage
   always_comb begin
      f_rounded    = {1'b0, e_prod_ff} + c2p_pkg::ROUND_HALF;
      f_phmag      = f_rounded[c2p_pkg::PROD_W:c2p_pkg::PHASE_SHIFT];
      rsp_phase_in = e_neg_ff ? $signed(-f_phmag) : $signed(f_phmag);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d_vld_ff     <= 1'b0;
         e_vld_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (ce) begin
         d_vld_ff     <= core_vld_ff[NCORE-1];
         e_vld_ff     <= d_vld_ff;
         rsp_valid_ff <= e_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         d_zero_ff         <= d_flags.re_zero && d_flags.im_zero;
         d_neg_ff          <= d_neg_in;
         d_mang_ff         <= d_mang_in;
         d_mag_ff          <= d_mag_in;
         e_zero_ff         <= d_zero_ff;
         e_neg_ff          <= d_neg_ff;
         e_mag_ff          <= d_mag_ff;
         e_prod_ff         <= e_prod_in;
         rsp_magnitude_ff  <= e_mag_ff;
         rsp_phase_ff      <= rsp_phase_in;
         rsp_zero_input_ff <= e_zero_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_magnitude  = rsp_magnitude_ff;
   assign rsp_phase      = rsp_phase_ff;
   assign rsp_zero_input = rsp_zero_input_ff;

`ifndef SYNTHESIS
   a_zero_result : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_zero_input_ff) |->
         (rsp_magnitude_ff == '0) && (rsp_phase_ff == '0))
      else $error("zero request gave a nonzero response");

   a_phase_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_phase_ff >= PHASE_MIN) && (rsp_phase_ff <= PHASE_MAX))
      else $error("phase outside -pi/2 .. 3pi/2");

   a_freeze : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |=> $stable(e_vld_ff) && $stable(e_prod_ff))
      else $error("pipeline moved while the response was stalled");

   a_advance : assert property (@(posedge clock) disable iff (reset)
      (e_vld_ff && ce) |=> rsp_valid_ff)
      else $error("request lost between scaling stage and output");
`endif

endmodule

FILE: bench/c2p_polar_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c2p_polar_checker
// Watches both channels of the cartesian to polar converter. Every accepted
// request is turned into the expected magnitude, phase and zero flag by a
// bit-exact predictor of the CORDIC and rounded root. Responses are matched
// in order against the oldest expectation.
// ----------------------------------------------------------------------------
module c2p_polar_checker #(
   parameter int DATA_WIDTH    = 16,
   parameter int CORDIC_STAGES = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_stall,
   input  logic signed [DATA_WIDTH-1:0]        req_real_part,
   input  logic signed [DATA_WIDTH-1:0]        req_imag_part,
   input  logic                                rsp_valid,
   input  logic                                rsp_stall,
   input  logic [c2p_pkg::MAG_W-1:0]           rsp_magnitude,
   input  logic signed [c2p_pkg::PHASE_W-1:0]  rsp_phase,
   input  logic                                rsp_zero_input,
   output int                                  mismatch_count,
   output int                                  outstanding
);

   typedef struct {
      logic [c2p_pkg::MAG_W-1:0]          magnitude;
      logic signed [c2p_pkg::PHASE_W-1:0] phase;
      logic                               zero_input;
   } polar_type;

   polar_type pending_polar[$];

   initial begin
      mismatch_count = 0;
      outstanding    = 0;
   end

   // right shift of the magnitude, sign put back afterwards
   function automatic longint shift_toward_zero(longint v, int s);
      if (v < 0) begin
         return -((-v) >> s);
      end
      return v >> s;
   endfunction

   function automatic polar_type polar_of(logic signed [DATA_WIDTH-1:0] re_in,
                                          logic signed [DATA_WIDTH-1:0] im_in);
      longint          re, im, are, aim, theta, ang, x, y, z, nx;
      longint unsigned sum, root, bitv, mang;
      logic [64:0]     product;
      int              stages;
      polar_type       p;
      re  = re_in;
      im  = im_in;
      are = (re < 0) ? -re : re;
      aim = (im < 0) ? -im : im;

      // rounded integer square root
      sum  = are * are + aim * aim;
      root = 0;
      bitv = 64'h4000_0000_0000_0000;
      while (bitv > sum) begin
         bitv = bitv >> 2;
      end
      while (bitv != 0) begin
         if (sum >= root + bitv) begin
            sum  = sum - (root + bitv);
            root = (root >> 1) + bitv;
         end else begin
            root = root >> 1;
         end
         bitv = bitv >> 2;
      end
      if (sum > root) begin
         root = root + 1;
      end
      if (root > longint'(c2p_pkg::MAG_MAX)) begin
         root = longint'(c2p_pkg::MAG_MAX);
      end

      // first-quadrant angle
      if (re == 0) begin
         theta = longint'(c2p_pkg::QUARTER_TURN);
      end else if (im == 0) begin
         theta = 0;
      end else begin
         stages = (CORDIC_STAGES > 32) ? 32 : CORDIC_STAGES;
         x = are << c2p_pkg::GUARD_SHIFT;
         y = aim << c2p_pkg::GUARD_SHIFT;
         z = 0;
         for (int i = 0; i < stages && y != 0; i++) begin
            if (y > 0) begin
               nx = x + shift_toward_zero(y, i);
               y  = y - shift_toward_zero(x, i);
               z  = z + longint'(c2p_pkg::ATAN_TURNS[i]);
            end else begin
               nx = x - shift_toward_zero(y, i);
               y  = y + shift_toward_zero(x, i);
               z  = z - longint'(c2p_pkg::ATAN_TURNS[i]);
            end
            x = nx;
         end
         if (z < 0) begin
            z = 0;
         end
         if (z > longint'(c2p_pkg::QUARTER_TURN)) begin
            z = longint'(c2p_pkg::QUARTER_TURN);
         end
         theta = z;
      end

      // quadrant correction
      if (re == 0 && im == 0) begin
         ang = 0;
      end else if (re > 0) begin
         ang = (im < 0) ? -theta : theta;
      end else if (re < 0) begin
         ang = (im < 0) ? longint'(c2p_pkg::HALF_TURN) + theta
                        : longint'(c2p_pkg::HALF_TURN) - theta;
      end else begin
         ang = (im > 0) ? longint'(c2p_pkg::QUARTER_TURN)
                        : -longint'(c2p_pkg::QUARTER_TURN);
      end

      // scale to 2^-13 rad, rounded half away from zero
      mang    = (ang < 0) ? -ang : ang;
      product = 65'(mang) * 65'(c2p_pkg::PI_Q30) + c2p_pkg::ROUND_HALF;
      product = product >> c2p_pkg::PHASE_SHIFT;

      p.magnitude  = root[c2p_pkg::MAG_W-1:0];
      p.phase      = (ang < 0) ? -product[c2p_pkg::PHASE_W-1:0]
                               : product[c2p_pkg::PHASE_W-1:0];
      p.zero_input = (re == 0 && im == 0);
      return p;
   endfunction

   always @(posedge clock) begin
      polar_type due;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            pending_polar.push_back(polar_of(req_real_part, req_imag_part));
         end
         if (rsp_valid && !rsp_stall) begin
            if (pending_polar.size() == 0) begin
               mismatch_count = mismatch_count + 1;
               if (mismatch_count <= 10) begin
                  $display("unexpected response: mag %0d phase %0d zero %0b",
                           rsp_magnitude, rsp_phase, rsp_zero_input);
               end
            end else begin
               due = pending_polar.pop_front();
               if (rsp_magnitude !== due.magnitude || rsp_phase !== due.phase ||
                   rsp_zero_input !== due.zero_input) begin
                  mismatch_count = mismatch_count + 1;
                  if (mismatch_count <= 10) begin
                     $display({"mismatch: expected mag %0d phase %0d zero %0b, ",
                               "got mag %0d phase %0d zero %0b"},
                              due.magnitude, due.phase, due.zero_input,
                              rsp_magnitude, rsp_phase, rsp_zero_input);
                  end
               end
            end
         end
         outstanding = pending_polar.size();
      end
   end

endmodule

FILE: bench/tb_cartesian_to_polar_converter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_cartesian_to_polar_converter
// Drives complex samples into the converter, first the axes, corners and
// quadrant edges, then random samples with random gaps and response stalls.
// The checker beside the block predicts and compares; this top gives the
// verdict once every expected response has come out.
// ----------------------------------------------------------------------------
module tb_cartesian_to_polar_converter;

   localparam int DATA_WIDTH    = 16;
   localparam int CORDIC_STAGES = 16;
   localparam int LATENCY       = ((CORDIC_STAGES > 16) ? CORDIC_STAGES : 16) + 6;
   localparam int NUM_RANDOM    = 1600;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int NUM_DIRECTED  = 24;

   localparam logic signed [DATA_WIDTH-1:0] DIRECTED_RE [NUM_DIRECTED] = '{
      0, 32767, -32768, 0, 0, 32767, -32768, 32767, -32768, 1, -1, 1,
      -1, 1, -1, 0, 0, 32767, 1, -32768, -32768, 100, -5, 12345
   };
   localparam logic signed [DATA_WIDTH-1:0] DIRECTED_IM [NUM_DIRECTED] = '{
      0, 0, 0, 32767, -32768, 32767, -32768, -32768, 32767, 1, -1, -1,
      1, 0, 0, 1, -1, 1, 32767, 1, -1, -3, 7, -23456
   };

   logic                               clock          = 1'b0;
   logic                               reset          = 1'b1;
   logic                               req_valid      = 1'b0;
   logic                               req_stall;
   logic signed [DATA_WIDTH-1:0]       req_real_part  = '0;
   logic signed [DATA_WIDTH-1:0]       req_imag_part  = '0;
   logic                               rsp_valid;
   logic                               rsp_stall      = 1'b0;
   logic [c2p_pkg::MAG_W-1:0]          rsp_magnitude;
   logic signed [c2p_pkg::PHASE_W-1:0] rsp_phase;
   logic                               rsp_zero_input;

   int mismatch_count;
   int outstanding;
   int cycle_count    = 0;
   int gap_pct        = 0;
   int stall_pct      = 0;
   bit quiet          = 1'b0;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   cartesian_to_polar_converter #(
      .DATA_WIDTH    (DATA_WIDTH),
      .CORDIC_STAGES (CORDIC_STAGES)
   ) i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_real_part  (req_real_part),
      .req_imag_part  (req_imag_part),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_magnitude  (rsp_magnitude),
      .rsp_phase      (rsp_phase),
      .rsp_zero_input (rsp_zero_input)
   );

   c2p_polar_checker #(
      .DATA_WIDTH    (DATA_WIDTH),
      .CORDIC_STAGES (CORDIC_STAGES)
   ) i_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_real_part  (req_real_part),
      .req_imag_part  (req_imag_part),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_magnitude  (rsp_magnitude),
      .rsp_phase      (rsp_phase),
      .rsp_zero_input (rsp_zero_input),
      .mismatch_count (mismatch_count),
      .outstanding    (outstanding)
   );

   // mostly full-range values, with small values, edges and zeros mixed in
   function automatic logic signed [DATA_WIDTH-1:0] random_part();
      int kind;
      kind = $urandom_range(0, 9);
      case (kind)
         6, 7: begin
            return DATA_WIDTH'($urandom_range(0, 64) - 32);
         end
         8: begin
            case ($urandom_range(0, 5))
               0: return DATA_WIDTH'(-32768);
               1: return DATA_WIDTH'(-32767);
               2: return DATA_WIDTH'(-1);
               3: return DATA_WIDTH'(1);
               4: return DATA_WIDTH'(32766);
               default: return DATA_WIDTH'(32767);
            endcase
         end
         9: begin
            return '0;
         end
         default: begin
            return DATA_WIDTH'($urandom());
         end
      endcase
   endfunction

   // holds the request until it is taken
   task automatic send_sample(logic signed [DATA_WIDTH-1:0] re,
                              logic signed [DATA_WIDTH-1:0] im);
      req_valid     <= 1'b1;
      req_real_part <= re;
      req_imag_part <= im;
      @(negedge clock);
      while (req_stall) begin
         @(negedge clock);
      end
      @(posedge clock);
   endtask

   task automatic wait_until_drained();
      @(negedge clock);
      while (outstanding != 0) begin
         @(negedge clock);
      end
      @(posedge clock);
   endtask

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // response side stalls in bursts
   initial begin
      @(posedge clock);
      forever begin
         if (!quiet && $urandom_range(0, 99) < stall_pct) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 19)) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
   end

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      for (int d = 0; d < NUM_DIRECTED; d++) begin
         send_sample(DIRECTED_RE[d], DIRECTED_IM[d]);
      end

      for (int n = 0; n < NUM_RANDOM; n++) begin
         if (n % 200 == 0) begin
            case ($urandom_range(0, 2))
               0: gap_pct = 0;
               1: gap_pct = 10;
               default: gap_pct = 40;
            endcase
            case ($urandom_range(0, 2))
               0: stall_pct = 0;
               1: stall_pct = 20;
               default: stall_pct = 50;
            endcase
         end
         if (n >= NUM_RANDOM - 200) begin
            quiet = 1'b1;
         end
         if (n == NUM_RANDOM / 2) begin
            req_valid <= 1'b0;
            wait_until_drained();
         end
         send_sample(random_part(), random_part());
         if (!quiet && $urandom_range(0, 99) < gap_pct) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clock);
         end
      end
      req_valid <= 1'b0;

      wait_until_drained();
      repeat (LATENCY + 8) @(posedge clock);

      if (mismatch_count == 0 && outstanding == 0) begin
         $display("tb: success");
      end else begin
         if (outstanding != 0) begin
            $display("%0d responses never arrived", outstanding);
         end
         $display("tb: failure");
      end
      $finish;
   end

endmodule
